@@ rtl/core/lhr_pkg.sv @@
// Shared types, operation codes and the default bound ladder of the latency
// histogram recorder. Depends on nothing; every other file imports it.
`default_nettype none

package lhr_pkg;

  // Field widths of the request and response words.
  localparam int FUNC_W     = 2;
  localparam int VALUE_W    = 64;
  localparam int INDEX_W    = 6;
  localparam int MAX_BOUNDS = 64;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [INDEX_W-1:0] index_t;

  // Operation codes. The fourth code does nothing and reports zeros besides min and max.
  localparam func_t FUNC_RECORD = 2'd0;
  localparam func_t FUNC_READ   = 2'd1;
  localparam func_t FUNC_CLEAR  = 2'd2;

  // Ladder construction constants.
  localparam int LADDER_STEP     = 100;
  localparam int LADDER_RESTART  = 1000;
  localparam int LINEAR_ENTRIES  = 9;
  localparam int DOUBLE_LIMIT    = 23;
  localparam int LEAD_LIMIT      = 30;
  localparam int DECIMAL_BASE    = 10;
  localparam int ROUND_STEPS     = 20;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Request word as it travels through the queue.
  typedef struct packed {
    func_t  func;
    index_t bucket_select;
    value_t sample_value;
  } req_word_t;

  // Bound of ladder entry idx. The design calls it only with constant arguments,
  // so there it folds to a constant at elaboration. All arithmetic wraps at 64 bits.
  function automatic value_t ladder_bound(int unsigned idx);
    value_t run;
    value_t lead;
    value_t scale;
    value_t result;
    run    = VALUE_W'(LADDER_STEP);
    result = '0;
    for (int unsigned i = 0; i < MAX_BOUNDS; i++) begin
      if (i < LINEAR_ENTRIES) begin
        if (i == idx) begin
          result = run * VALUE_W'(i + 1);
        end
      end else begin
        if (run == VALUE_W'(LADDER_STEP)) begin
          run = VALUE_W'(LADDER_RESTART);
        end
        lead  = run;
        scale = VALUE_W'(1);
        for (int k = 0; k < ROUND_STEPS; k++) begin
          if (lead > VALUE_W'(LEAD_LIMIT)) begin
            lead  = lead / VALUE_W'(DECIMAL_BASE);
            scale = scale * VALUE_W'(DECIMAL_BASE);
          end
        end
        if (i == idx) begin
          result = lead * scale;
        end
        run = (i < DOUBLE_LIMIT) ? (run << 1) : (run << 2);
      end
    end
    return result;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lhr_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on lhr_pkg for the field types.
`default_nettype none

interface lhr_req_if import lhr_pkg::*; ();
  logic   valid;
  logic   ready;
  func_t  func;
  value_t sample_value;
  index_t bucket_select;

  modport source (output valid, func, sample_value, bucket_select, input ready);
  modport sink   (input valid, func, sample_value, bucket_select, output ready);
endinterface

interface lhr_rsp_if import lhr_pkg::*; ();
  logic   valid;
  logic   ready;
  index_t bucket_index;
  value_t hit_count;
  value_t value_sum;
  value_t lower_bound;
  value_t min_value;
  value_t max_value;

  modport source (output valid, bucket_index, hit_count, value_sum, lower_bound,
                  min_value, max_value, input ready);
  modport sink   (input valid, bucket_index, hit_count, value_sum, lower_bound,
                  min_value, max_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lhr_front.sv @@
// Front part: takes request words and classifies each sample against the
// bound ladder. Depends on lhr_pkg and lhr_req_if.
`default_nettype none

module lhr_front import lhr_pkg::*; #(
  parameter int NUM_BOUNDS = 32
) (
  lhr_req_if.sink                               req,
  output logic                                  push_valid,
  output logic [$bits(req_word_t)+NUM_BOUNDS-1:0] push_data,
  input  logic                                  push_ready
);

  logic [NUM_BOUNDS-1:0] at_or_above;
  req_word_t             word;

  // One compare per bound; a zero sample is above none of them.
  for (genvar g = 0; g < NUM_BOUNDS; g++) begin : g_cmp
    assign at_or_above[g] = (req.sample_value != '0) &&
                            (req.sample_value >= ladder_bound(g));
  end

  // Pack the word together with its compare vector for the queue.
  assign word.func          = req.func;
  assign word.bucket_select = req.bucket_select;
  assign word.sample_value  = req.sample_value;

  assign push_data  = {word, at_or_above};
  assign push_valid = req.valid;
  assign req.ready  = push_ready;

endmodule

`default_nettype wire

@@ rtl/core/lhr_queue.sv @@
// Short queue that decouples the classifying front from the bucket back.
// Depends on lhr_pkg for its depth.
`default_nettype none

module lhr_queue import lhr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count; the depth is a power of two so pointers wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lhr_back.sv @@
// Back part: picks the bucket, updates hit and sum memories, tracks the
// minimum and maximum and registers the response word. Depends on lhr_pkg
// and lhr_rsp_if.
`default_nettype none

module lhr_back import lhr_pkg::*; #(
  parameter int NUM_BOUNDS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  logic [$bits(req_word_t)+NUM_BOUNDS-1:0] pop_data,
  lhr_rsp_if.source                             rsp
);

  localparam int NUM_BUCKETS = NUM_BOUNDS + 1;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);

  typedef logic [BKT_W-1:0] bkt_t;

  // Head of the queue.
  req_word_t             head;
  logic [NUM_BOUNDS-1:0] head_ge;
  bkt_t                  head_bucket;
  logic                  head_in_range;
  bkt_t                  head_addr;
  index_t                head_index;
  logic                  advance;
  logic                  pop;

  // Second stage.
  logic   s2_valid;
  func_t  s2_func;
  value_t s2_sample;
  bkt_t   s2_addr;
  index_t s2_index;
  logic   s2_in_range;

  // Bucket storage and its bookkeeping.
  value_t                 hits_mem [NUM_BUCKETS];
  value_t                 sums_mem [NUM_BUCKETS];
  value_t                 rd_hits;
  value_t                 rd_sums;
  logic [NUM_BUCKETS-1:0] entry_valid;
  logic                   byp_en;
  bkt_t                   byp_addr;
  value_t                 byp_hits;
  value_t                 byp_sums;

  // Lower bounds by bucket: zero for bucket 0, else the bound below it.
  value_t lower_tab [NUM_BUCKETS];

  value_t min_seen;
  value_t max_seen;
  value_t min_next;
  value_t max_next;
  value_t hit_base;
  value_t sum_base;
  value_t new_hits;
  value_t new_sums;
  value_t lower;
  index_t res_index;
  value_t res_hits;
  value_t res_sums;
  value_t res_low;
  logic   record_now;
  logic   clear_now;

  assign lower_tab[0] = '0;
  for (genvar g = 1; g < NUM_BUCKETS; g++) begin : g_low
    assign lower_tab[g] = ladder_bound(g - 1);
  end

  assign {head, head_ge} = pop_data;

  // Bucket is the first bound that the sample stays below.
  always_comb begin
    head_bucket = BKT_W'(NUM_BOUNDS);
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if (!head_ge[i]) begin
        head_bucket = BKT_W'(i);
      end
    end
  end

  assign head_in_range = ({1'b0, head.bucket_select} <= (INDEX_W + 1)'(NUM_BOUNDS));

  // Memory address and reported index of the head word.
  always_comb begin
    head_addr  = '0;
    head_index = '0;
    case (head.func)
      FUNC_RECORD: begin
        head_addr  = head_bucket;
        head_index = INDEX_W'(head_bucket);
      end
      FUNC_READ: begin
        head_addr  = head_in_range ? BKT_W'(head.bucket_select) : '0;
        head_index = head.bucket_select;
      end
      default: begin
        head_addr  = '0;
        head_index = '0;
      end
    endcase
  end

  // The whole back part moves when the response register can take a word.
  assign advance   = !rsp.valid || rsp.ready;
  assign pop_ready = advance;
  assign pop       = pop_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_func     <= head.func;
      s2_sample   <= head.sample_value;
      s2_addr     <= head_addr;
      s2_index    <= head_index;
      s2_in_range <= head_in_range;
    end
  end

  assign record_now = advance && s2_valid && (s2_func == FUNC_RECORD);
  assign clear_now  = advance && s2_valid && (s2_func == FUNC_CLEAR);

  // Registered read and single write port of the bucket memories.
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_hits <= hits_mem[head_addr];
      rd_sums <= sums_mem[head_addr];
    end
    if (record_now) begin
      hits_mem[s2_addr] <= new_hits;
      sums_mem[s2_addr] <= new_sums;
    end
  end

  // Per-bucket valid bits stand in for zeroing the memories.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (clear_now) begin
      entry_valid <= '0;
    end else if (record_now) begin
      entry_valid[s2_addr] <= 1'b1;
    end
  end

  // The read issued alongside a write misses it; keep that write for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_en <= 1'b0;
    end else if (advance) begin
      byp_en <= record_now;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byp_addr <= s2_addr;
      byp_hits <= new_hits;
      byp_sums <= new_sums;
    end
  end

  // Current contents of the selected bucket.
  always_comb begin
    if (byp_en && (byp_addr == s2_addr)) begin
      hit_base = byp_hits;
      sum_base = byp_sums;
    end else if (entry_valid[s2_addr]) begin
      hit_base = rd_hits;
      sum_base = rd_sums;
    end else begin
      hit_base = '0;
      sum_base = '0;
    end
  end

  assign new_hits = hit_base + VALUE_W'(1);
  assign new_sums = sum_base + s2_sample;
  assign lower    = lower_tab[s2_addr];

  // Maximum first; otherwise the minimum, which is replaced while it is zero.
  always_comb begin
    min_next = min_seen;
    max_next = max_seen;
    case (s2_func)
      FUNC_RECORD: begin
        if (s2_sample > max_seen) begin
          max_next = s2_sample;
        end else if ((s2_sample < min_seen) || (min_seen == '0)) begin
          min_next = s2_sample;
        end
      end
      FUNC_CLEAR: begin
        min_next = '0;
        max_next = '0;
      end
      default: begin
        min_next = min_seen;
        max_next = max_seen;
      end
    endcase
  end

  // Response fields by operation.
  always_comb begin
    res_index = '0;
    res_hits  = '0;
    res_sums  = '0;
    res_low   = '0;
    case (s2_func)
      FUNC_RECORD: begin
        res_index = s2_index;
        res_hits  = new_hits;
        res_sums  = new_sums;
        res_low   = lower;
      end
      FUNC_READ: begin
        res_index = s2_index;
        if (s2_in_range) begin
          res_hits = hit_base;
          res_sums = sum_base;
          res_low  = lower;
        end
      end
      default: begin
        res_index = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen <= '0;
      max_seen <= '0;
    end else if (advance && s2_valid) begin
      min_seen <= min_next;
      max_seen <= max_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      rsp.bucket_index <= res_index;
      rsp.hit_count    <= res_hits;
      rsp.value_sum    <= res_sums;
      rsp.lower_bound  <= res_low;
      rsp.min_value    <= min_next;
      rsp.max_value    <= max_next;
    end
  end

`ifndef ASSERT_OFF
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear_now |=> (entry_valid == '0))
    else $error("bucket valid bits not cleared by clear");

  a_bypass_valid: assert property (@(posedge clk) disable iff (rst)
    byp_en |-> entry_valid[byp_addr])
    else $error("forwarded bucket is not marked valid");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    min_seen <= max_seen)
    else $error("tracked minimum exceeds tracked maximum");

  a_record_counts: assert property (@(posedge clk) disable iff (rst)
    record_now |=> (rsp.valid && (rsp.hit_count != '0)))
    else $error("record produced no response or a zero hit count");
`endif

endmodule

`default_nettype wire

@@ rtl/core/latency_histogram_recorder_top.sv @@
// Latency histogram recorder: 33 by default (NUM_BOUNDS + 1) buckets of
// 64-bit hit counts and wrapping sums, with a running minimum and maximum.
//
// Channels: req carries one word per operation (func, sample_value,
// bucket_select); rsp returns exactly one word per request, in order
// (bucket_index, hit_count, value_sum, lower_bound, min_value, max_value).
// A word moves when valid and ready are both high at a rising edge of clk.
//
// An accepted request passes through the queue, the second-stage register and
// the response register. Throughput: one word per cycle while rsp is not
// stalled, for any mix of record, read and clear; a clear empties all buckets.
// A record that follows a record to the same bucket is forwarded, so no bubble is needed.
//
// Reset (rst, synchronous): all buckets read as zero, minimum and maximum are
// zero, the queue and response register are empty.
// Stall: when rsp.ready is low the response register holds its word, the back
// part freezes, and the two-entry queue keeps taking requests until full;
// req.ready then drops.
// Depends on lhr_pkg, lhr_if, lhr_front, lhr_queue and lhr_back.
`default_nettype none

module latency_histogram_recorder_top import lhr_pkg::*; #(
  parameter int NUM_BOUNDS = 32
) (
  input  logic      clk,
  input  logic      rst,
  lhr_req_if.sink   req,
  lhr_rsp_if.source rsp
);

  localparam int ENTRY_W = $bits(req_word_t) + NUM_BOUNDS;

  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  lhr_front #(.NUM_BOUNDS(NUM_BOUNDS)) u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  lhr_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lhr_back #(.NUM_BOUNDS(NUM_BOUNDS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ dv/lhr_response_checker.sv @@
// Response checker for the latency histogram recorder: watches both channels,
// predicts each response word from its own histogram state and compares.
// Depends on lhr_pkg and the channel interfaces in lhr_if.
module lhr_response_checker import lhr_pkg::*; #(
  parameter int NUM_BOUNDS = 32
) (
  input  logic clk,
  input  logic rst,
  lhr_req_if   req,
  lhr_rsp_if   rsp,
  output int   errors,
  output int   outstanding,
  output int   words_checked
);

  // One response word as the block should report it.
  typedef struct packed {
    index_t bucket_index;
    value_t hit_count;
    value_t value_sum;
    value_t lower_bound;
    value_t min_value;
    value_t max_value;
  } bucket_report_t;

  // Cap on printed mismatches so a broken design does not flood the log.
  localparam int SHOW_LIMIT = 40;

  // Ladder construction figures.
  localparam int LINEAR_COUNT  = 9;
  localparam int FIRST_STEP    = 100;
  localparam int RESTART_VALUE = 1000;
  localparam int DOUBLING_END  = 23;
  localparam int LEAD_MAX      = 30;

  value_t hit_tally [NUM_BOUNDS+1];
  value_t sum_tally [NUM_BOUNDS+1];
  value_t bound_ladder [NUM_BOUNDS];
  value_t low_mark;
  value_t high_mark;
  int     shown;

  bucket_report_t predicted_reports [$];

  // Default bound ladder: linear steps of 100, then a doubling and later
  // quadrupling run, each entry rounded down to at most 30 times a power of ten.
  initial begin
    value_t run;
    value_t lead;
    value_t scale;
    run = value_t'(FIRST_STEP);
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      if (i < LINEAR_COUNT) begin
        bound_ladder[i] = run * value_t'(i + 1);
      end else begin
        if (run == value_t'(FIRST_STEP)) begin
          run = value_t'(RESTART_VALUE);
        end
        lead  = run;
        scale = 64'd1;
        while (lead > value_t'(LEAD_MAX)) begin
          lead  = lead / 64'd10;
          scale = scale * 64'd10;
        end
        bound_ladder[i] = lead * scale;
        run = (i < DOUBLING_END) ? run * 64'd2 : run * 64'd4;
      end
    end
  end

  function automatic value_t bucket_floor(int b);
    return (b == 0) ? '0 : bound_ladder[b-1];
  endfunction

  // Applies one request word to the histogram state and returns the response.
  function automatic bucket_report_t histogram_apply(func_t f, value_t s, index_t sel);
    bucket_report_t r;
    int b;
    r = '0;
    case (f)
      FUNC_RECORD: begin
        // A minimum of zero is always replaced unless the sample raised the max.
        if (s > high_mark) begin
          high_mark = s;
        end else if (s < low_mark || low_mark == '0) begin
          low_mark = s;
        end
        b = 0;
        if (s != '0) begin
          while (b < NUM_BOUNDS && s >= bound_ladder[b]) b++;
        end
        hit_tally[b] = hit_tally[b] + 64'd1;
        sum_tally[b] = sum_tally[b] + s;
        r.bucket_index = index_t'(b);
        r.hit_count    = hit_tally[b];
        r.value_sum    = sum_tally[b];
        r.lower_bound  = bucket_floor(b);
      end
      FUNC_READ: begin
        // Out-of-range reads echo the index with zero contents.
        r.bucket_index = sel;
        if (int'(sel) <= NUM_BOUNDS) begin
          r.hit_count   = hit_tally[sel];
          r.value_sum   = sum_tally[sel];
          r.lower_bound = bucket_floor(int'(sel));
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i <= NUM_BOUNDS; i++) begin
          hit_tally[i] = '0;
          sum_tally[i] = '0;
        end
        low_mark  = '0;
        high_mark = '0;
      end
      default: begin
      end
    endcase
    r.min_value = low_mark;
    r.max_value = high_mark;
    return r;
  endfunction

  function automatic int field_bad(string name, value_t want, value_t seen);
    if (want === seen) return 0;
    if (shown < SHOW_LIMIT) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
    end
    shown++;
    return 1;
  endfunction

  // Compare response words first, then record the newly accepted request word.
  always @(posedge clk) begin
    bucket_report_t want;
    int bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i <= NUM_BOUNDS; i++) begin
        hit_tally[i] = '0;
        sum_tally[i] = '0;
      end
      low_mark  = '0;
      high_mark = '0;
      predicted_reports.delete();
      errors        <= 0;
      outstanding   <= 0;
      words_checked <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (predicted_reports.size() == 0) begin
          if (shown < SHOW_LIMIT) begin
            $display("%0t: response word with none expected: expected nothing, actual index %0d",
                     $time, rsp.bucket_index);
          end
          shown++;
          bad++;
        end else begin
          want = predicted_reports.pop_front();
          bad += field_bad("bucket_index", 64'(want.bucket_index), 64'(rsp.bucket_index));
          bad += field_bad("hit_count",    want.hit_count,   rsp.hit_count);
          bad += field_bad("value_sum",    want.value_sum,   rsp.value_sum);
          bad += field_bad("lower_bound",  want.lower_bound, rsp.lower_bound);
          bad += field_bad("min_value",    want.min_value,   rsp.min_value);
          bad += field_bad("max_value",    want.max_value,   rsp.max_value);
        end
        words_checked <= words_checked + 1;
      end
      if (req.valid && req.ready) begin
        predicted_reports.push_back(
          histogram_apply(req.func, req.sample_value, req.bucket_select));
      end
      errors      <= errors + bad;
      outstanding <= predicted_reports.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Top of the latency histogram recorder testbench: clock, reset, request and
// response-side stimulus, and the verdict. Depends on lhr_pkg, lhr_if, the
// recorder top and lhr_response_checker.
module tb;
  import lhr_pkg::*;

  localparam int NUM_BOUNDS   = 32;
  localparam int RANDOM_WORDS = 1100;
  localparam int CALM_FIRST   = 400;
  localparam int CALM_LAST    = 599;
  localparam int IDLE_PCT     = 38;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT      = 2000000;

  // The block does nothing for the fourth operation code.
  localparam func_t FUNC_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm;
  int   err_cnt;
  int   outstanding;
  int   words_checked;
  int   n_record;
  int   n_read;
  int   n_clear;
  int   n_spare;
  value_t ladder [NUM_BOUNDS];

  lhr_req_if req_ch ();
  lhr_rsp_if rsp_ch ();

  latency_histogram_recorder_top #(.NUM_BOUNDS(NUM_BOUNDS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lhr_response_checker #(.NUM_BOUNDS(NUM_BOUNDS)) chk (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .errors        (err_cnt),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  always #5 clk = ~clk;

  // Response side: random back-pressure, none during the calm stretch.
  always @(posedge clk) begin
    if (calm) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic value_t rand64();
    return {$urandom, $urandom};
  endfunction

  // Samples cluster around bucket edges, with full-range and tiny values mixed in.
  function automatic value_t pick_sample();
    int k;
    k = $urandom_range(NUM_BOUNDS - 1);
    case ($urandom_range(9))
      0: return '0;
      1: return ladder[k];
      2: return ladder[k] - 64'd1;
      3: return ladder[k] + 64'd1;
      4: return rand64();
      5: return '1 - value_t'($urandom_range(3));
      6: return value_t'($urandom_range(1999));
      7: return rand64() >> $urandom_range(63);
      8: return ladder[k] + value_t'($urandom_range(99));
      default: return value_t'($urandom_range(99));
    endcase
  endfunction

  // Offers one request word after a random idle gap (none when calm) and waits for its acceptance.
  task automatic send_word(func_t f, value_t s, index_t sel);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.func          <= f;
    req_ch.sample_value  <= s;
    req_ch.bucket_select <= sel;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    case (f)
      FUNC_RECORD: n_record++;
      FUNC_READ:   n_read++;
      FUNC_CLEAR:  n_clear++;
      default:     n_spare++;
    endcase
  endtask

  initial begin
    int r;
    req_ch.valid         = 1'b0;
    req_ch.func          = FUNC_RECORD;
    req_ch.sample_value  = '0;
    req_ch.bucket_select = '0;
    for (int i = 0; i < NUM_BOUNDS; i++) ladder[i] = ladder_bound(i);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: empty reads, bucket edges, top bucket, sum wrap,
    // out-of-range reads, the spare code and the zero-minimum rule after clear.
    send_word(FUNC_READ,   '0, '0);
    send_word(FUNC_SPARE,  '0, '0);
    send_word(FUNC_RECORD, '0, '0);
    send_word(FUNC_RECORD, 64'd1, '0);
    send_word(FUNC_RECORD, 64'd99, '0);
    send_word(FUNC_RECORD, 64'd100, '0);
    send_word(FUNC_RECORD, 64'd101, '0);
    send_word(FUNC_RECORD, 64'd900, '0);
    send_word(FUNC_RECORD, 64'd999, '0);
    send_word(FUNC_RECORD, 64'd1000, '0);
    send_word(FUNC_RECORD, ladder[NUM_BOUNDS-1] - 64'd1, '0);
    send_word(FUNC_RECORD, ladder[NUM_BOUNDS-1], '0);
    send_word(FUNC_RECORD, '1, '1);
    send_word(FUNC_RECORD, '1, '1);
    send_word(FUNC_RECORD, 64'd5, '0);
    send_word(FUNC_READ,   '1, index_t'(NUM_BOUNDS));
    send_word(FUNC_READ,   '0, index_t'(NUM_BOUNDS + 1));
    send_word(FUNC_READ,   '0, '1);
    send_word(FUNC_READ,   '0, index_t'(1));
    send_word(FUNC_SPARE,  '1, '1);
    send_word(FUNC_CLEAR,  '1, '1);
    send_word(FUNC_READ,   '0, index_t'(NUM_BOUNDS));
    send_word(FUNC_RECORD, 64'd7, '0);
    send_word(FUNC_RECORD, 64'd3, '0);
    send_word(FUNC_READ,   '0, '0);

    // Random words, mostly records, with junk in the fields an operation ignores.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= CALM_FIRST && n <= CALM_LAST);
      r = $urandom_range(999);
      if (r < 720) begin
        send_word(FUNC_RECORD, pick_sample(), index_t'($urandom));
      end else if (r < 940) begin
        send_word(FUNC_READ, rand64(), ($urandom_range(99) < 85) ?
                  index_t'($urandom_range(NUM_BOUNDS)) :
                  index_t'($urandom_range(63, NUM_BOUNDS + 1)));
      end else if (r < 985) begin
        send_word(FUNC_SPARE, rand64(), index_t'($urandom));
      end else begin
        send_word(FUNC_CLEAR, rand64(), index_t'($urandom));
      end
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    // Drain: let the checker see the last push, then wait for every response word.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d records, %0d reads, %0d clears and %0d spare-code words;",
             n_record, n_read, n_clear, n_spare);
    $display("checked %0d response words with random idling on both channels.",
             words_checked);
    if (err_cnt == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing response words.
  initial begin
    #(TIMEOUT);
    $display("Timeout with %0d response words still expected.", outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
